// ===== sv/fit_policy_block_allocator_macros.svh =====
// Assertion macros for the checker file fpba_chk.sv.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPBA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/fpba_pkg.sv =====
package fpba_pkg;

    // Default sizes of the block table.
    localparam int BLOCK_COUNT_DEF = 16;
    localparam int SIZE_BITS_DEF   = 16;

    // Only blocks that the slot field can address take part.
    localparam int SLOT_LIMIT = 16;

    // Placement rules; any other code behaves as first fit.
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    // Command codes of an input item.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Controls from the sequencer to the compare unit.
    typedef struct packed {
        logic       have;
        logic [1:0] policy;
    } alu_ctl_t;

    // Status from the compare unit to the sequencer.
    typedef struct packed {
        logic fits;
        logic take;
    } alu_stat_t;

    // One result item.
    typedef struct packed {
        logic        found;
        logic [3:0]  chosen_block;
        logic [15:0] left_over;
    } rsp_t;

endpackage

// ===== sv/fpba_req_if.sv =====
interface fpba_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [3:0]  block_slot;
    logic [15:0] amount;

    modport source (output valid, output cmd, output block_slot, output amount,
                    input ready);
    modport sink (input valid, input cmd, input block_slot, input amount,
                  output ready);
endinterface

// ===== sv/fpba_rsp_if.sv =====
interface fpba_rsp_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [3:0]  chosen_block;
    logic [15:0] left_over;

    modport source (output valid, output found, output chosen_block, output left_over,
                    input ready);
    modport sink (input valid, input found, input chosen_block, input left_over,
                  output ready);
endinterface

// ===== sv/fit_policy_block_allocator.sv =====
// Load item: the result passes the FINISH state into the output register; the next item
// is taken once it has moved on. Allocate item: the sequencer sweeps all min(BLOCK_COUNT, 16)
// slots through the compare unit, one block a cycle, then passes WRITE and FINISH likewise.
// An output register lets the next item in while a result waits to be taken.
// Reset (rst_n, asynchronous, active low) clears every free size and the policy
// to first fit; the block is ready as soon as reset is released.
module fit_policy_block_allocator #(
    parameter int BLOCK_COUNT = fpba_pkg::BLOCK_COUNT_DEF,
    parameter int SIZE_BITS   = fpba_pkg::SIZE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    fpba_req_if.sink          req,
    fpba_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_wdata
);
    import fpba_pkg::*;

    localparam int SLOTS     = (BLOCK_COUNT < SLOT_LIMIT) ? BLOCK_COUNT : SLOT_LIMIT;
    localparam int SLOT_BITS = $clog2(SLOTS);

    logic [1:0]           fit_policy_reg;
    logic                 out_valid_reg;
    rsp_t                 out_reg;

    logic                 tbl_we;
    logic [SLOT_BITS-1:0] tbl_waddr;
    logic [SIZE_BITS-1:0] tbl_wdata;
    logic [SLOT_BITS-1:0] tbl_raddr;
    logic [SIZE_BITS-1:0] tbl_rdata;
    logic [SIZE_BITS-1:0] alu_a;
    logic [SIZE_BITS-1:0] alu_b;
    logic [SIZE_BITS-1:0] alu_best;
    logic [SIZE_BITS-1:0] alu_diff;
    alu_ctl_t             alu_ctl;
    alu_stat_t            alu_stat;
    logic                 res_valid;
    logic                 res_ready;
    rsp_t                 res;

    // Placement rule register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg <= POL_FIRST;
        end
        else if (cfg_we)
        begin
            fit_policy_reg <= cfg_wdata;
        end
    end

    fpba_table #(
        .DEPTH     (SLOTS),
        .WIDTH     (SIZE_BITS),
        .ADDR_BITS (SLOT_BITS)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    fpba_alu #(
        .WIDTH (SIZE_BITS)
    ) u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .best (alu_best),
        .ctl  (alu_ctl),
        .diff (alu_diff),
        .stat (alu_stat)
    );

    fpba_ctrl #(
        .SLOTS     (SLOTS),
        .SIZE_BITS (SIZE_BITS),
        .SLOT_BITS (SLOT_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .cmd        (req.cmd),
        .block_slot (req.block_slot),
        .amount     (req.amount),
        .policy     (fit_policy_reg),
        .tbl_we     (tbl_we),
        .tbl_waddr  (tbl_waddr),
        .tbl_wdata  (tbl_wdata),
        .tbl_raddr  (tbl_raddr),
        .tbl_rdata  (tbl_rdata),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_best   (alu_best),
        .alu_ctl    (alu_ctl),
        .alu_diff   (alu_diff),
        .alu_stat   (alu_stat),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // Output register: takes a finished result whenever it is empty or being drained.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.found        = out_reg.found;
    assign rsp.chosen_block = out_reg.chosen_block;
    assign rsp.left_over    = out_reg.left_over;

endmodule

// ===== sv/fpba_table.sv =====
module fpba_table #(
    parameter int DEPTH     = 16,
    parameter int WIDTH     = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] size_reg [DEPTH];

    // Free sizes start at zero and are written one entry at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                size_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            size_reg[waddr] <= wdata;
        end
    end

    // The sequencer walks the entries through a single read port.
    assign rdata = size_reg[raddr];

endmodule

// ===== sv/fpba_alu.sv =====
module fpba_alu #(
    parameter int WIDTH = 16
) (
    input  logic [WIDTH-1:0]    a,
    input  logic [WIDTH-1:0]    b,
    input  logic [WIDTH-1:0]    best,
    input  fpba_pkg::alu_ctl_t  ctl,
    output logic [WIDTH-1:0]    diff,
    output fpba_pkg::alu_stat_t stat
);
    import fpba_pkg::*;

    logic [WIDTH:0] sub;
    logic           smaller;
    logic           larger;

    // One subtractor gives both the fit test and the remaining size.
    assign sub  = {1'b0, a} - {1'b0, b};
    assign diff = sub[WIDTH-1:0];

    // Comparison of the candidate against the best block so far.
    assign smaller = a < best;
    assign larger  = a > best;

    always_comb
    begin
        stat.fits = ~sub[WIDTH];
        unique case (ctl.policy)
            POL_BEST:  stat.take = stat.fits && (!ctl.have || smaller);
            POL_WORST: stat.take = stat.fits && (!ctl.have || larger);
            default:   stat.take = stat.fits && !ctl.have;
        endcase
    end

endmodule

// ===== sv/fpba_ctrl.sv =====
module fpba_ctrl #(
    parameter int SLOTS     = 16,
    parameter int SIZE_BITS = 16,
    parameter int SLOT_BITS = $clog2(SLOTS)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Input item
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     cmd,
    input  logic [3:0]               block_slot,
    input  logic [15:0]              amount,
    input  logic [1:0]               policy,
    // Block table
    output logic                     tbl_we,
    output logic [SLOT_BITS-1:0]     tbl_waddr,
    output logic [SIZE_BITS-1:0]     tbl_wdata,
    output logic [SLOT_BITS-1:0]     tbl_raddr,
    input  logic [SIZE_BITS-1:0]     tbl_rdata,
    // Shared compare unit
    output logic [SIZE_BITS-1:0]     alu_a,
    output logic [SIZE_BITS-1:0]     alu_b,
    output logic [SIZE_BITS-1:0]     alu_best,
    output fpba_pkg::alu_ctl_t       alu_ctl,
    input  logic [SIZE_BITS-1:0]     alu_diff,
    input  fpba_pkg::alu_stat_t      alu_stat,
    // Finished result towards the output register
    output logic                     res_valid,
    input  logic                     res_ready,
    output fpba_pkg::rsp_t           res
);
    import fpba_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_WRITE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    localparam logic [4:0]           SLOT_END  = 5'(SLOTS);
    localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(SLOTS - 1);

    logic [1:0]           state_reg,    state_next;
    logic [SLOT_BITS-1:0] idx_reg,      idx_next;
    logic [SIZE_BITS-1:0] amt_reg,      amt_next;
    logic                 have_reg,     have_next;
    logic [SIZE_BITS-1:0] best_val_reg, best_val_next;
    logic [SLOT_BITS-1:0] best_idx_reg, best_idx_next;
    rsp_t                 res_reg,      res_next;

    logic                   accept;
    logic                   slot_ok;
    logic [SIZE_BITS+15:0]  amt_wide;
    logic [SIZE_BITS-1:0]   amt_in;
    logic [SIZE_BITS+15:0]  amt_out_wide;
    logic [SIZE_BITS+15:0]  rest_wide;
    logic [SLOT_BITS+3:0]   best_idx_wide;

    // The amount is cut to the block size width; results show the low 16 bits.
    assign amt_wide      = {SIZE_BITS'(0), amount};
    assign amt_in        = amt_wide[SIZE_BITS-1:0];
    assign amt_out_wide  = {16'b0, amt_in};
    assign rest_wide     = {16'b0, alu_diff};
    assign best_idx_wide = {4'b0, best_idx_reg};

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign slot_ok  = {1'b0, block_slot} < SLOT_END;

    // Compare unit operands: the scanned entry during the sweep, the chosen one after.
    assign alu_a        = (state_reg == ST_SCAN) ? tbl_rdata : best_val_reg;
    assign alu_b        = amt_reg;
    assign alu_best     = best_val_reg;
    assign alu_ctl.have   = have_reg;
    assign alu_ctl.policy = policy;

    assign tbl_raddr = idx_reg;

    // Table writes: a load at acceptance, or the reduced size after a sweep.
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            tbl_we    = accept && (cmd == CMD_LOAD) && slot_ok;
            tbl_waddr = block_slot[SLOT_BITS-1:0];
            tbl_wdata = amt_in;
        end
        else
        begin
            tbl_we    = (state_reg == ST_WRITE) && have_reg;
            tbl_waddr = best_idx_reg;
            tbl_wdata = alu_diff;
        end
    end

    assign res_valid = (state_reg == ST_FINISH);
    assign res       = res_reg;

    // Sequencer: accept, for an allocation sweep every slot and write back, hand over the result.
    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        amt_next      = amt_reg;
        have_next     = have_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        res_next      = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    amt_next      = amt_in;
                    idx_next      = '0;
                    have_next     = 1'b0;
                    best_val_next = '0;
                    best_idx_next = '0;
                    if (cmd == CMD_LOAD)
                    begin
                        res_next.found        = slot_ok;
                        res_next.chosen_block = block_slot;
                        res_next.left_over    = slot_ok ? amt_out_wide[15:0] : 16'd0;
                        state_next            = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (alu_stat.take)
                begin
                    have_next     = 1'b1;
                    best_val_next = tbl_rdata;
                    best_idx_next = idx_reg;
                end
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (have_reg)
                begin
                    res_next.found        = 1'b1;
                    res_next.chosen_block = best_idx_wide[3:0];
                    res_next.left_over    = rest_wide[15:0];
                end
                else
                begin
                    res_next = '0;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            have_reg  <= have_next;
        end
    end

    // Working values of the sweep and the finished result.
    always_ff @(posedge clk)
    begin
        amt_reg      <= amt_next;
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
    end

endmodule

// ===== sv/fpba_chk.sv =====
`include "fit_policy_block_allocator_macros.svh"

module fpba_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_found,
    input logic [3:0]  rsp_chosen_block,
    input logic [15:0] rsp_left_over
);

    // A stalled result stays offered.
    `FPBA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `FPBA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_found) && $stable(rsp_chosen_block) && $stable(rsp_left_over), "result changed while stalled")

    // Once an item is taken the block is busy with it and not ready in the next cycle.
    `FPBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready, "ready right after an accepted item")

    // A refused load or a failed allocation never reports a remaining size.
    `FPBA_ASSERT_SAME(a_not_found_zero, clk, rst_n, rsp_valid && !rsp_found, rsp_left_over == 16'd0, "non-zero size without a placement")

endmodule

bind fit_policy_block_allocator fpba_chk u_fpba_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_found        (rsp.found),
    .rsp_chosen_block (rsp.chosen_block),
    .rsp_left_over    (rsp.left_over)
);
